### rtl/scanline_fetch_pixel_decoder_unit_defines.svh
// ----------------------------------------------------------------------------
// scanline fetch pixel decoder unit - assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef SCANLINE_FETCH_PIXEL_DECODER_UNIT_DEFINES_SVH
`define SCANLINE_FETCH_PIXEL_DECODER_UNIT_DEFINES_SVH

// plain property that must hold at every edge out of reset
`define SFPD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// antecedent in this cycle implies consequent in the next
`define SFPD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sfpd_pkg.sv
// ----------------------------------------------------------------------------
// sfpd_pkg
// types and constants shared by the scanline fetch and pixel decoder
// ----------------------------------------------------------------------------
package sfpd_pkg;

  localparam int unsigned AddrW   = 18;
  localparam int unsigned PenW    = 5;
  localparam int unsigned NumPix  = 8;
  localparam int unsigned NumPens = 16;
  localparam int unsigned CountW  = 7;
  localparam int unsigned CfgW    = 40;
  localparam int unsigned OutDataW = 64;

  // input item kinds
  localparam logic FUNC_DESC = 1'b0;
  localparam logic FUNC_DATA = 1'b1;

  // pixel modes
  localparam logic [1:0] MODE_1BPP = 2'd0;
  localparam logic [1:0] MODE_2BPP = 2'd1;
  localparam logic [1:0] MODE_4BPP = 2'd2;

  // configuration register indexes
  localparam logic [1:0] CFG_VIDEO_CTRL = 2'd0;
  localparam logic [1:0] CFG_PENS_LOW   = 2'd1;
  localparam logic [1:0] CFG_PENS_HIGH  = 2'd2;

  // video control bits
  localparam int unsigned VC_ENABLE_BIT  = 6;
  localparam int unsigned VC_REVERSE_BIT = 7;

  typedef logic [PenW-1:0] pen_t;
  typedef pen_t [NumPens-1:0] pen_table_t;

  typedef struct packed {
    logic [7:0] video_ctrl;
    pen_table_t pens;
  } cfg_t;

  // classified item handed from the front to the back
  typedef struct packed {
    logic             is_data;
    logic [7:0]       data;
    logic [1:0]       mode;
    logic [AddrW-1:0] fetch_addr;
    logic             line_done;
  } cmd_t;

endpackage

### rtl/sfpd_front.sv
// ----------------------------------------------------------------------------
// sfpd_front
// takes descriptor and data requests, tracks address, mode and byte count
// ----------------------------------------------------------------------------
module sfpd_front #(
  parameter int unsigned BytesPerLine = 80
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic                 in_func_i,
  input  logic [15:0]          in_word_i,
  output logic                 in_ready_o,
  input  logic                 q_full_i,
  output logic                 push_o,
  output sfpd_pkg::cmd_t       cmd_o
);
  import sfpd_pkg::*;

  localparam logic [CountW-1:0] LastCount = CountW'(BytesPerLine);

  logic [AddrW-1:0]  addr_q, addr_d;
  logic [1:0]        mode_q, mode_d;
  logic [CountW-1:0] count_q, count_d;
  logic [CountW-1:0] count_inc;
  logic              done;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;
  assign count_inc  = count_q + 1'b1;

  always_comb begin
    addr_d  = addr_q;
    mode_d  = mode_q;
    count_d = count_q;
    done    = 1'b0;
    if (in_func_i == FUNC_DESC) begin
      addr_d  = {in_word_i[13:0], 4'b0000};
      mode_d  = in_word_i[15:14];
      count_d = '0;
    end else begin
      // only the low 16 bits count, the bank bits stay
      addr_d = {addr_q[AddrW-1:16], addr_q[15:0] + 16'd1};
      if (count_inc == LastCount) begin
        done    = 1'b1;
        count_d = '0;
      end else begin
        count_d = count_inc;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q  <= '0;
      mode_q  <= MODE_1BPP;
      count_q <= '0;
    end else if (push_o) begin
      addr_q  <= addr_d;
      mode_q  <= mode_d;
      count_q <= count_d;
    end
  end

  always_comb begin
    cmd_o.is_data    = (in_func_i == FUNC_DATA);
    cmd_o.data       = in_word_i[7:0];
    cmd_o.mode       = mode_q;
    cmd_o.fetch_addr = addr_d;
    cmd_o.line_done  = done;
  end

endmodule

### rtl/sfpd_queue.sv
// ----------------------------------------------------------------------------
// sfpd_queue
// two-entry queue of classified requests between front and back
// ----------------------------------------------------------------------------
`include "scanline_fetch_pixel_decoder_unit_defines.svh"

module sfpd_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  sfpd_pkg::cmd_t push_data_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output sfpd_pkg::cmd_t head_o
);
  import sfpd_pkg::*;

  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign valid_o = (count_q != 2'd0);
  assign head_o  = mem_q[rd_ptr_q];

  always_comb begin
    count_d = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      count_q <= count_d;
    end
  end

  `SFPD_ASSERT(a_count_range, count_q != 2'd3, "queue count out of range")
  `SFPD_ASSERT(a_no_pop_empty, !(pop_i && !valid_o), "pop from empty queue")
  `SFPD_ASSERT(a_ptr_match, (count_q == 2'd1) == (wr_ptr_q != rd_ptr_q), "queue pointers off")

endmodule

### rtl/sfpd_back.sv
// ----------------------------------------------------------------------------
// sfpd_back
// decodes a data byte into eight pens and holds the result register
// ----------------------------------------------------------------------------
`include "scanline_fetch_pixel_decoder_unit_defines.svh"

module sfpd_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  sfpd_pkg::cfg_t              cfg_i,
  input  logic                        q_valid_i,
  input  sfpd_pkg::cmd_t              q_head_i,
  output logic                        pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [sfpd_pkg::AddrW-1:0]  fetch_addr_o,
  output sfpd_pkg::pen_t [7:0]        pixels_o,
  output sfpd_pkg::pen_t              border_o,
  output logic                        pixels_valid_o,
  output logic                        line_done_o
);
  import sfpd_pkg::*;

  logic             valid_q;
  logic [AddrW-1:0] addr_q;
  pen_t [7:0]       pix_q, pix_d;
  pen_t             border_q, border_d;
  logic             pvalid_q;
  logic             done_q;
  logic [3:0]       idx;

  assign pop_o = q_valid_i && (!valid_q || out_ready_i);

  always_comb begin
    if (cfg_i.video_ctrl[VC_REVERSE_BIT]) begin
      border_d = cfg_i.pens[1];
    end else begin
      border_d = cfg_i.video_ctrl[PenW-1:0];
    end
  end

  always_comb begin
    pix_d = '0;
    idx   = '0;
    for (int i = 0; i < NumPix; i++) begin
      case (q_head_i.mode)
        MODE_1BPP: idx = {3'b000, q_head_i.data[7-i]};
        MODE_2BPP: idx = {2'b00, q_head_i.data[6-2*(i/2) +: 2]};
        default:   idx = (i < 4) ? q_head_i.data[7:4] : q_head_i.data[3:0];
      endcase
      if (!q_head_i.is_data) begin
        pix_d[i] = '0;
      end else if (!cfg_i.video_ctrl[VC_ENABLE_BIT]) begin
        pix_d[i] = border_d;
      end else begin
        pix_d[i] = cfg_i.pens[idx];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      addr_q   <= q_head_i.fetch_addr;
      pix_q    <= pix_d;
      border_q <= border_d;
      pvalid_q <= q_head_i.is_data;
      done_q   <= q_head_i.line_done;
    end
  end

  assign out_valid_o    = valid_q;
  assign fetch_addr_o   = addr_q;
  assign pixels_o       = pix_q;
  assign border_o       = border_q;
  assign pixels_valid_o = pvalid_q;
  assign line_done_o    = done_q;

  `SFPD_ASSERT(a_done_on_data, !(valid_q && done_q && !pvalid_q), "line end on descriptor")
  `SFPD_ASSERT_NEXT(a_pop_loads, pop_o, valid_q, "result register not loaded")

endmodule

### rtl/scanline_fetch_pixel_decoder_unit.sv
// A taken request is written into the queue; the back pops it into the result register.
// Throughput: one request per cycle while the master side takes results, set by the front
// state update and the decode into the result register.
// A two-entry queue lets the front keep taking requests while a result stalls.
// Reset clears the address, mode, byte count, queue and the three configuration registers.
// ----------------------------------------------------------------------------
// scanline_fetch_pixel_decoder_unit
// video line engine: fetch address walk and byte to eight-pen decode
// ----------------------------------------------------------------------------
module scanline_fetch_pixel_decoder_unit #(
  parameter int unsigned BYTES_PER_LINE = 80
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [15:0] s_axis_tdata_i,   // word_in[15:0]
  input  logic        s_axis_tuser_i,   // func
  // stream out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // fetch_address[17:0], pixel0..pixel7 [57:18], border_pen[62:58], zero[63]
  output logic [63:0] m_axis_tdata_o,
  output logic        m_axis_tuser_o,   // pixels_valid
  output logic        m_axis_tlast_o,   // line_done
  // configuration writes
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_addr_i,
  input  logic [39:0] cfg_data_i
);
  import sfpd_pkg::*;

  logic [7:0]      vctrl_q;
  logic [CfgW-1:0] pens_lo_q, pens_hi_q;
  cfg_t            cfg;
  logic            push, q_full, q_valid, pop;
  cmd_t            push_cmd, head_cmd;
  logic [AddrW-1:0] fetch_addr;
  pen_t [7:0]      pixels;
  pen_t            border;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vctrl_q   <= '0;
      pens_lo_q <= '0;
      pens_hi_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_addr_i)
        CFG_VIDEO_CTRL: vctrl_q   <= cfg_data_i[7:0];
        CFG_PENS_LOW:   pens_lo_q <= cfg_data_i;
        CFG_PENS_HIGH:  pens_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign cfg.video_ctrl = vctrl_q;
  assign cfg.pens       = {pens_hi_q, pens_lo_q};

  sfpd_front #(
    .BytesPerLine(BYTES_PER_LINE)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_func_i  (s_axis_tuser_i),
    .in_word_i  (s_axis_tdata_i),
    .in_ready_o (s_axis_tready_o),
    .q_full_i   (q_full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  sfpd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (q_full),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .head_o      (head_cmd)
  );

  sfpd_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .q_valid_i      (q_valid),
    .q_head_i       (head_cmd),
    .pop_o          (pop),
    .out_valid_o    (m_axis_tvalid_o),
    .out_ready_i    (m_axis_tready_i),
    .fetch_addr_o   (fetch_addr),
    .pixels_o       (pixels),
    .border_o       (border),
    .pixels_valid_o (m_axis_tuser_o),
    .line_done_o    (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {1'b0, border, pixels[7], pixels[6], pixels[5], pixels[4],
                           pixels[3], pixels[2], pixels[1], pixels[0], fetch_addr};

endmodule
